// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define CHK_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("port check failed");

// consequent holds the cycle after the antecedent
`define CHK_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("port sequence check failed");

`endif

// File: hdl/ctmc_pkg.sv
package ctmc_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned COORD_W   = 11;
   localparam int unsigned COUNT_W   = 23;
   localparam int unsigned SUM_W     = 33;
   localparam int unsigned MAX_DIM   = 2048;
   localparam int unsigned COUNT_CAP = 4194304;
   localparam int unsigned NUM_REGS  = 6;
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int unsigned STEP_W    = $clog2(COORD_W);
   localparam int unsigned REM_W     = SUM_W - COORD_W + 1;

   typedef enum logic [IDX_W-1:0] {
      REG_HUE_LOW  = 3'd0,
      REG_HUE_HIGH = 3'd1,
      REG_SAT_LOW  = 3'd2,
      REG_SAT_HIGH = 3'd3,
      REG_VAL_LOW  = 3'd4,
      REG_VAL_HIGH = 3'd5
   } reg_index_type;

   localparam logic [CHAN_W-1:0] HUE_LOW_RESET  = 8'd110;
   localparam logic [CHAN_W-1:0] HUE_HIGH_RESET = 8'd130;
   localparam logic [CHAN_W-1:0] SAT_LOW_RESET  = 8'd50;
   localparam logic [CHAN_W-1:0] SAT_HIGH_RESET = 8'd255;
   localparam logic [CHAN_W-1:0] VAL_LOW_RESET  = 8'd50;
   localparam logic [CHAN_W-1:0] VAL_HIGH_RESET = 8'd255;

   typedef struct packed {
      logic [SUM_W-1:0]   sum_col;
      logic [SUM_W-1:0]   sum_row;
      logic [COUNT_W-1:0] count;
   } frame_sum_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hdl/ctmc_front.sv
module ctmc_front import ctmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAN_W-1:0]   req_hue,
   input  logic [CHAN_W-1:0]   req_saturation,
   input  logic [CHAN_W-1:0]   req_brightness,
   input  logic [COORD_W-1:0]  req_column,
   input  logic [COORD_W-1:0]  req_row,
   input  logic                req_frame_end,
   input  logic                csr_write_enable,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [CHAN_W-1:0]   csr_write_data,
   input  q_status_type        q_status,
   output logic                q_push,
   output frame_sum_type       q_data
);

   logic [CHAN_W-1:0]  hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [CHAN_W-1:0]  val_low_ff, val_high_ff;
   logic [SUM_W-1:0]   sum_col_ff, sum_col_in, sum_row_ff, sum_row_in;
   logic [SUM_W-1:0]   next_col, next_row;
   logic [COUNT_W-1:0] count_ff, count_in, next_count;
   logic               accept, fg, add;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   assign fg = (req_hue >= hue_low_ff) && (req_hue <= hue_high_ff) &&
               (req_saturation >= sat_low_ff) && (req_saturation <= sat_high_ff) &&
               (req_brightness >= val_low_ff) && (req_brightness <= val_high_ff) &&
               (32'(req_column) < MAX_DIM) && (32'(req_row) < MAX_DIM);
   assign add = fg && (32'(count_ff) < COUNT_CAP);

   always_comb begin
      next_col   = sum_col_ff + (add ? SUM_W'(req_column) : '0);
      next_row   = sum_row_ff + (add ? SUM_W'(req_row) : '0);
      next_count = count_ff + (add ? COUNT_W'(1) : '0);
      sum_col_in = sum_col_ff;
      sum_row_in = sum_row_ff;
      count_in   = count_ff;
      if (accept) begin
         if (req_frame_end) begin
            sum_col_in = '0;
            sum_row_in = '0;
            count_in   = '0;
         end else begin
            sum_col_in = next_col;
            sum_row_in = next_row;
            count_in   = next_count;
         end
      end
   end

   assign q_push         = accept && req_frame_end;
   assign q_data.sum_col = next_col;
   assign q_data.sum_row = next_row;
   assign q_data.count   = next_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_col_ff <= '0;
         sum_row_ff <= '0;
         count_ff   <= '0;
      end else begin
         sum_col_ff <= sum_col_in;
         sum_row_ff <= sum_row_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= HUE_LOW_RESET;
         hue_high_ff <= HUE_HIGH_RESET;
         sat_low_ff  <= SAT_LOW_RESET;
         sat_high_ff <= SAT_HIGH_RESET;
         val_low_ff  <= VAL_LOW_RESET;
         val_high_ff <= VAL_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_HUE_LOW:  hue_low_ff  <= csr_write_data;
            REG_HUE_HIGH: hue_high_ff <= csr_write_data;
            REG_SAT_LOW:  sat_low_ff  <= csr_write_data;
            REG_SAT_HIGH: sat_high_ff <= csr_write_data;
            REG_VAL_LOW:  val_low_ff  <= csr_write_data;
            REG_VAL_HIGH: val_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

endmodule

// File: hdl/ctmc_fifo.sv
module ctmc_fifo import ctmc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_sum_type push_data,
   input  logic          pop,
   output frame_sum_type pop_data,
   output q_status_type  status
);

   frame_sum_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign status.full  = (32'(fill_ff) == QUEUE_DEPTH);
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/ctmc_back.sv
module ctmc_back import ctmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  q_status_type        q_status,
   input  frame_sum_type       q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_centroid_col,
   output logic [COORD_W-1:0]  rsp_centroid_row,
   output logic [COUNT_W-1:0]  rsp_pixel_count,
   output logic                rsp_no_pixels
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [REM_W-2:0]    rem_col_ff, rem_col_in, rem_row_ff, rem_row_in;
   logic [COORD_W-1:0]  dvd_col_ff, dvd_col_in, dvd_row_ff, dvd_row_in;
   logic [COORD_W-1:0]  quo_col_ff, quo_col_in, quo_row_ff, quo_row_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   logic [COORD_W-1:0]  out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                out_empty_ff, out_empty_in;
   logic [REM_W-1:0]    sh_col, sh_row;
   logic [REM_W:0]      diff_col, diff_row;
   logic                ge_col, ge_row, out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // one restoring step per cycle on both coordinates
   assign sh_col   = {rem_col_ff, dvd_col_ff[COORD_W-1]};
   assign sh_row   = {rem_row_ff, dvd_row_ff[COORD_W-1]};
   assign diff_col = {1'b0, sh_col} - (REM_W+1)'(div_ff);
   assign diff_row = {1'b0, sh_row} - (REM_W+1)'(div_ff);
   assign ge_col   = !diff_col[REM_W];
   assign ge_row   = !diff_row[REM_W];

   always_comb begin
      state_in     = state_ff;
      rem_col_in   = rem_col_ff;
      rem_row_in   = rem_row_ff;
      dvd_col_in   = dvd_col_ff;
      dvd_row_in   = dvd_row_ff;
      quo_col_in   = quo_col_ff;
      quo_row_in   = quo_row_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_count_in = out_count_ff;
      out_empty_in = out_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop      = 1'b1;
               div_in     = q_data.count;
               rem_col_in = (REM_W-1)'(q_data.sum_col[SUM_W-1:COORD_W]);
               rem_row_in = (REM_W-1)'(q_data.sum_row[SUM_W-1:COORD_W]);
               dvd_col_in = q_data.sum_col[COORD_W-1:0];
               dvd_row_in = q_data.sum_row[COORD_W-1:0];
               quo_col_in = '0;
               quo_row_in = '0;
               step_in    = STEP_W'(COORD_W - 1);
               state_in   = (q_data.count == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_col_in = ge_col ? diff_col[REM_W-2:0] : sh_col[REM_W-2:0];
            rem_row_in = ge_row ? diff_row[REM_W-2:0] : sh_row[REM_W-2:0];
            dvd_col_in = {dvd_col_ff[COORD_W-2:0], 1'b0};
            dvd_row_in = {dvd_row_ff[COORD_W-2:0], 1'b0};
            quo_col_in = {quo_col_ff[COORD_W-2:0], ge_col};
            quo_row_in = {quo_row_ff[COORD_W-2:0], ge_row};
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_col_in   = quo_col_ff;
               out_row_in   = quo_row_ff;
               out_count_in = div_ff;
               out_empty_in = (div_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_col_ff   <= rem_col_in;
      rem_row_ff   <= rem_row_in;
      dvd_col_ff   <= dvd_col_in;
      dvd_row_ff   <= dvd_row_in;
      quo_col_ff   <= quo_col_in;
      quo_row_ff   <= quo_row_in;
      div_ff       <= div_in;
      step_ff      <= step_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_count_ff <= out_count_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_centroid_col = out_col_ff;
   assign rsp_centroid_row = out_row_ff;
   assign rsp_pixel_count  = out_count_ff;
   assign rsp_no_pixels    = out_empty_ff;

endmodule

// File: hdl/color_threshold_mask_centroid.sv
// HSV threshold mask with per-frame centroid of the foreground pixels.
// req channel: one pixel item per clock while req_stall is low (hue,
// saturation, brightness, column, row, frame_end). A pixel is
// foreground when each channel lies within its inclusive csr bounds;
// foreground positions are summed and counted.
// csr port: write-only, registers 0..5 are hue/sat/val low/high bounds.
// rsp channel: one item per frame, carrying mean column and row, count
// and the no_pixels flag. Sums go through the queue, divider and output
// register (an empty frame skips the divide state); the divider resolves
// one quotient bit per cycle, both coordinates together.
// Frame sums pass through a two-entry queue; req_stall is high only while
// that queue holds two frames not yet started by the divider.
// A stalled rsp item holds in the output register while the divider
// starts on the next queued frame.
// Reset (synchronous) restores the default bounds, clears the sums and
// empties the queue and the output register.
module color_threshold_mask_centroid import ctmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAN_W-1:0]   req_hue,
   input  logic [CHAN_W-1:0]   req_saturation,
   input  logic [CHAN_W-1:0]   req_brightness,
   input  logic [COORD_W-1:0]  req_column,
   input  logic [COORD_W-1:0]  req_row,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_centroid_col,
   output logic [COORD_W-1:0]  rsp_centroid_row,
   output logic [COUNT_W-1:0]  rsp_pixel_count,
   output logic                rsp_no_pixels,
   input  logic                csr_write_enable,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [CHAN_W-1:0]   csr_write_data
);

   q_status_type  q_status;
   frame_sum_type push_data, pop_data;
   logic          q_push, q_pop;

   ctmc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue          (req_hue),
      .req_saturation   (req_saturation),
      .req_brightness   (req_brightness),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_frame_end    (req_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   ctmc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   ctmc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_centroid_col (rsp_centroid_col),
      .rsp_centroid_row (rsp_centroid_row),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_no_pixels    (rsp_no_pixels)
   );

endmodule

// File: hdl/ctmc_checker.sv
`include "assert_macros.svh"

module ctmc_checker import ctmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [COORD_W-1:0]  rsp_centroid_col,
   input  logic [COORD_W-1:0]  rsp_centroid_row,
   input  logic [COUNT_W-1:0]  rsp_pixel_count,
   input  logic                rsp_no_pixels
);

   logic empty_ok, count_ok, cap_ok;

   assign empty_ok = !(rsp_valid && rsp_no_pixels) ||
                     (rsp_centroid_col == '0 && rsp_centroid_row == '0 &&
                      rsp_pixel_count == '0);
   assign count_ok = !(rsp_valid && !rsp_no_pixels) || (rsp_pixel_count != '0);
   assign cap_ok   = !rsp_valid || (32'(rsp_pixel_count) <= COUNT_CAP);

   // an empty frame reports all zero
   `CHK_ALWAYS(a_empty_zero, empty_ok)

   // a non-empty frame reports a nonzero count
   `CHK_ALWAYS(a_count_nonzero, count_ok)

   // count never passes the cap
   `CHK_ALWAYS(a_count_cap, cap_ok)

   // a stalled result stays offered
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_count))

endmodule

bind color_threshold_mask_centroid ctmc_checker u_ctmc_checker (.*);

// File: bench/centroid_checker.sv
`timescale 1ns / 100ps

module centroid_checker import ctmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [CHAN_W-1:0]  req_hue,
   input  logic [CHAN_W-1:0]  req_saturation,
   input  logic [CHAN_W-1:0]  req_brightness,
   input  logic [COORD_W-1:0] req_column,
   input  logic [COORD_W-1:0] req_row,
   input  logic               req_frame_end,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [COORD_W-1:0] rsp_centroid_col,
   input  logic [COORD_W-1:0] rsp_centroid_row,
   input  logic [COUNT_W-1:0] rsp_pixel_count,
   input  logic               rsp_no_pixels,
   input  logic               csr_write_enable,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CHAN_W-1:0]  csr_write_data,
   output int                 open_frames,
   output int                 fail_count
);

   typedef struct packed {
      logic [COORD_W-1:0] centroid_col;
      logic [COORD_W-1:0] centroid_row;
      logic [COUNT_W-1:0] pixel_count;
      logic               no_pixels;
   } centroid_type;

   logic [CHAN_W-1:0]  hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
   logic [SUM_W-1:0]   col_sum, row_sum;
   logic [COUNT_W-1:0] fg_pixels;
   centroid_type       centroid_q[$];
   centroid_type       frame_centroid;
   centroid_type       seen_centroid;

   initial begin
      fail_count = 0;
      open_frames = 0;
   end

   function automatic logic is_foreground(input logic [CHAN_W-1:0] h, s, v,
                                          input logic [COORD_W-1:0] c, r);
      return h >= hue_lo && h <= hue_hi && s >= sat_lo && s <= sat_hi &&
             v >= val_lo && v <= val_hi && c < MAX_DIM && r < MAX_DIM;
   endfunction

   task automatic check_field(input string name, input logic [COUNT_W-1:0] expected,
                              input logic [COUNT_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s expected %0d actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hue_lo = HUE_LOW_RESET;
         hue_hi = HUE_HIGH_RESET;
         sat_lo = SAT_LOW_RESET;
         sat_hi = SAT_HIGH_RESET;
         val_lo = VAL_LOW_RESET;
         val_hi = VAL_HIGH_RESET;
         col_sum = '0;
         row_sum = '0;
         fg_pixels = '0;
         centroid_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (is_foreground(req_hue, req_saturation, req_brightness, req_column, req_row)
                && fg_pixels < COUNT_CAP) begin
               col_sum = col_sum + SUM_W'(req_column);
               row_sum = row_sum + SUM_W'(req_row);
               fg_pixels = fg_pixels + 1'b1;
            end
            if (req_frame_end) begin
               frame_centroid = '0;
               if (fg_pixels == 0) begin
                  frame_centroid.no_pixels = 1'b1;
               end else begin
                  frame_centroid.centroid_col = COORD_W'(col_sum / fg_pixels);
                  frame_centroid.centroid_row = COORD_W'(row_sum / fg_pixels);
                  frame_centroid.pixel_count = fg_pixels;
               end
               centroid_q = {centroid_q, frame_centroid};
               col_sum = '0;
               row_sum = '0;
               fg_pixels = '0;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_HUE_LOW:  hue_lo = csr_write_data;
               REG_HUE_HIGH: hue_hi = csr_write_data;
               REG_SAT_LOW:  sat_lo = csr_write_data;
               REG_SAT_HIGH: sat_hi = csr_write_data;
               REG_VAL_LOW:  val_lo = csr_write_data;
               REG_VAL_HIGH: val_hi = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (centroid_q.size() == 0) begin
               $error("result item with no frame waiting");
               fail_count++;
            end else begin
               seen_centroid = centroid_q.pop_front();
               check_field("centroid_col", COUNT_W'(seen_centroid.centroid_col),
                           COUNT_W'(rsp_centroid_col));
               check_field("centroid_row", COUNT_W'(seen_centroid.centroid_row),
                           COUNT_W'(rsp_centroid_row));
               check_field("pixel_count", seen_centroid.pixel_count, rsp_pixel_count);
               check_field("no_pixels", COUNT_W'(seen_centroid.no_pixels),
                           COUNT_W'(rsp_no_pixels));
            end
         end
      end
      open_frames <= centroid_q.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ctmc_pkg::*;

   localparam logic [IDX_W-1:0] UNMAPPED_INDEX_LO = 3'd6;
   localparam logic [IDX_W-1:0] UNMAPPED_INDEX_HI = 3'd7;
   localparam int DRAIN_CYCLES = 24;
   localparam int ITEMS_PER_SETTING = 61;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CHAN_W-1:0]  req_hue = '0;
   logic [CHAN_W-1:0]  req_saturation = '0;
   logic [CHAN_W-1:0]  req_brightness = '0;
   logic [COORD_W-1:0] req_column = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic               req_frame_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COORD_W-1:0] rsp_centroid_col;
   logic [COORD_W-1:0] rsp_centroid_row;
   logic [COUNT_W-1:0] rsp_pixel_count;
   logic               rsp_no_pixels;
   logic               csr_write_enable = 1'b0;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [CHAN_W-1:0]  csr_write_data = '0;
   int                 open_frames;
   int                 fail_count;

   int                 send_idle_pct = 17;
   int                 recv_idle_pct = 58;
   logic [CHAN_W-1:0]  bounds [NUM_REGS];

   color_threshold_mask_centroid i_dut (.*);

   centroid_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_pixel(input logic [CHAN_W-1:0] h, s, v,
                             input logic [COORD_W-1:0] c, r, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= h;
      req_saturation <= s;
      req_brightness <= v;
      req_column <= c;
      req_row <= r;
      req_frame_end <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_frames != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CHAN_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_bounds(input logic [CHAN_W-1:0] hl, hh, sl, sh, vl, vh);
      wait_idle();
      write_reg(REG_HUE_LOW, hl);
      write_reg(REG_HUE_HIGH, hh);
      write_reg(REG_SAT_LOW, sl);
      write_reg(REG_SAT_HIGH, sh);
      write_reg(REG_VAL_LOW, vl);
      write_reg(REG_VAL_HIGH, vh);
      // unmapped index, must leave every bound alone
      write_reg($urandom_range(1) ? UNMAPPED_INDEX_HI : UNMAPPED_INDEX_LO, CHAN_W'($urandom));
      bounds[REG_HUE_LOW] = hl;
      bounds[REG_HUE_HIGH] = hh;
      bounds[REG_SAT_LOW] = sl;
      bounds[REG_SAT_HIGH] = sh;
      bounds[REG_VAL_LOW] = vl;
      bounds[REG_VAL_HIGH] = vh;
   endtask

   function automatic logic [CHAN_W-1:0] pick_channel(input logic [CHAN_W-1:0] lo, hi);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return (lo <= hi) ? CHAN_W'($urandom_range(hi, lo)) : CHAN_W'($urandom);
         5: return lo;
         6: return hi;
         7: return lo - 1'b1;
         8: return hi + 1'b1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++) begin
         send_pixel(pick_channel(bounds[REG_HUE_LOW], bounds[REG_HUE_HIGH]),
                    pick_channel(bounds[REG_SAT_LOW], bounds[REG_SAT_HIGH]),
                    pick_channel(bounds[REG_VAL_LOW], bounds[REG_VAL_HIGH]),
                    pick_coord(), pick_coord(), i == len - 1);
      end
   endtask

   task automatic run_frames(input int quota);
      int sent;
      int len;
      sent = 0;
      while (sent < quota) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
         send_frame(len);
         sent += len;
      end
   endtask

   initial begin
      bounds[REG_HUE_LOW] = HUE_LOW_RESET;
      bounds[REG_HUE_HIGH] = HUE_HIGH_RESET;
      bounds[REG_SAT_LOW] = SAT_LOW_RESET;
      bounds[REG_SAT_HIGH] = SAT_HIGH_RESET;
      bounds[REG_VAL_LOW] = VAL_LOW_RESET;
      bounds[REG_VAL_HIGH] = VAL_HIGH_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default bounds: empty frame, bound edges, foreground last pixel
      send_pixel(8'd0, 8'd100, 8'd100, 11'd10, 11'd10, 1'b1);
      send_pixel(8'd110, 8'd50, 8'd50, 11'd0, 11'd0, 1'b0);
      send_pixel(8'd130, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1);
      send_pixel(8'd109, 8'd100, 8'd100, 11'd3, 11'd4, 1'b0);
      send_pixel(8'd131, 8'd100, 8'd100, 11'd3, 11'd4, 1'b0);
      send_pixel(8'd120, 8'd49, 8'd100, 11'd3, 11'd4, 1'b0);
      send_pixel(8'd120, 8'd100, 8'd49, 11'd3, 11'd4, 1'b0);
      send_pixel(8'd255, 8'd100, 8'd100, 11'd3, 11'd4, 1'b0);
      send_pixel(8'd120, 8'd100, 8'd100, 11'd5, 11'd7, 1'b1);

      // inverted hue bounds
      set_bounds(8'd130, 8'd110, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(8'd120, 8'd100, 8'd100, 11'd1, 11'd1, 1'b0);
      send_pixel(8'd110, 8'd100, 8'd100, 11'd2, 11'd2, 1'b0);
      send_pixel(8'd130, 8'd100, 8'd100, 11'd3, 11'd3, 1'b1);

      // everything foreground, hue above 179 included, truncating means
      set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0, 11'd2047, 11'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 11'd0, 11'd2047, 1'b1);
      send_pixel(8'd200, 8'd1, 8'd2, 11'd2047, 11'd2047, 1'b1);
      send_pixel(8'd1, 8'd2, 8'd3, 11'd1, 11'd2047, 1'b0);
      send_pixel(8'd4, 8'd5, 8'd6, 11'd2, 11'd2046, 1'b0);
      send_pixel(8'd7, 8'd8, 8'd9, 11'd2, 11'd0, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int k = 0; k < 6; k++) begin
            case (k)
               0: set_bounds(HUE_LOW_RESET, HUE_HIGH_RESET, SAT_LOW_RESET, SAT_HIGH_RESET,
                             VAL_LOW_RESET, VAL_HIGH_RESET);
               1: set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
               2: set_bounds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
               3: set_bounds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
               4: begin
                  bounds[REG_HUE_LOW] = CHAN_W'($urandom);
                  bounds[REG_SAT_LOW] = CHAN_W'($urandom);
                  bounds[REG_VAL_LOW] = CHAN_W'($urandom);
                  set_bounds(bounds[REG_HUE_LOW], bounds[REG_HUE_LOW], bounds[REG_SAT_LOW],
                             bounds[REG_SAT_LOW], bounds[REG_VAL_LOW], bounds[REG_VAL_LOW]);
               end
               default: set_bounds(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                                   CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
            endcase
            run_frames(ITEMS_PER_SETTING);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
